/* hw/rtl/lmps_pkg.sv */
package lmps_pkg;

  // Panel geometry
  localparam int MATRIX_COLUMNS  = 64;
  localparam int SUBMATRIX_COUNT = 5;

  localparam int SUBROWS    = 8;
  localparam int SUBFRAMES  = 255;
  localparam int COLOURS    = 3;
  localparam int CHAN_W     = 8;
  localparam int PIXEL_W    = COLOURS * CHAN_W;
  localparam int SERIAL_W   = 15;
  localparam int SUBROW_W   = 3;
  localparam int SUBFRAME_W = 8;
  localparam int ROW_W      = 6;
  localparam int COLIN_W    = 6;

  // Only submatrices whose bits fit the serial field are stored
  localparam int MAX_LANES  = SERIAL_W / COLOURS;
  localparam int LANES      = (SUBMATRIX_COUNT < MAX_LANES) ? SUBMATRIX_COUNT : MAX_LANES;
  localparam int LANE_W     = 3;
  localparam int STORE_ROWS = SUBMATRIX_COUNT * SUBROWS;

  localparam int COL_W       = $clog2(MATRIX_COLUMNS);
  localparam int ADDR_W      = SUBROW_W + COL_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Result buffer
  localparam int OB_DEPTH = 4;
  localparam int OB_PTR_W = $clog2(OB_DEPTH);
  localparam int OB_CNT_W = $clog2(OB_DEPTH + 1);

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_USED_W  = SUBROW_W + SERIAL_W + SUBFRAME_W;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_TICK  = 1'b1
  } req_e;

  typedef struct packed {
    req_e                  kind;
    logic [LANE_W-1:0]     lane;
    logic [ADDR_W-1:0]     addr;
    logic [PIXEL_W-1:0]    pixel;
    logic [SUBROW_W-1:0]   row_select;
    logic                  latch_after;
    logic                  frame_end;
    logic [SUBFRAME_W-1:0] subframe;
  } op_t;

  typedef struct packed {
    logic [SUBROW_W-1:0]   row_select;
    logic [SERIAL_W-1:0]   serial_bits;
    logic                  latch_after;
    logic                  frame_end;
    logic [SUBFRAME_W-1:0] subframe;
  } res_t;

  typedef struct packed {
    logic clearing;
  } bstat_t;

endpackage

/* hw/rtl/lmps_queue.sv */
module lmps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lmps_pkg::op_t  op_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lmps_pkg::op_t  op_o
);

  lmps_pkg::op_t                   slot_q [lmps_pkg::Q_DEPTH];
  logic [lmps_pkg::Q_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [lmps_pkg::Q_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [lmps_pkg::Q_CNT_W-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == lmps_pkg::Q_CNT_W'(lmps_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign op_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + lmps_pkg::Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + lmps_pkg::Q_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + lmps_pkg::Q_CNT_W'(push_i) - lmps_pkg::Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

/* hw/rtl/lmps_front.sv */
module lmps_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lmps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  lmps_pkg::bstat_t                    bstat_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output lmps_pkg::op_t                       op_o
);

  logic [lmps_pkg::ROW_W-1:0]      pixel_row;
  logic [lmps_pkg::COLIN_W-1:0]    pixel_col;
  logic [lmps_pkg::CHAN_W-1:0]     red_value, green_value, blue_value;
  lmps_pkg::req_e                  kind;
  logic [lmps_pkg::COL_W+5:0]      col_wide;
  logic                            in_range, accept;
  logic                            last_col, last_row, last_sf;

  logic [lmps_pkg::COL_W-1:0]      col_q, col_d;
  logic [lmps_pkg::SUBROW_W-1:0]   subrow_q, subrow_d;
  logic [lmps_pkg::SUBFRAME_W-1:0] subframe_q, subframe_d;

  always_comb begin
    pixel_row   = s_axis_tdata[5:0];
    pixel_col   = s_axis_tdata[11:6];
    red_value   = s_axis_tdata[19:12];
    green_value = s_axis_tdata[27:20];
    blue_value  = s_axis_tdata[35:28];
    kind        = lmps_pkg::req_e'(s_axis_tuser);
    col_wide    = (lmps_pkg::COL_W + 6)'(pixel_col);
  end

  // Hold off input while the frame store is being swept or the queue is full
  assign s_axis_tready = !bstat_i.clearing && !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_range = ({1'b0, pixel_row} < 7'(lmps_pkg::STORE_ROWS))
            && (pixel_row[5:3] < lmps_pkg::LANE_W'(lmps_pkg::LANES))
            && (col_wide < (lmps_pkg::COL_W + 6)'(lmps_pkg::MATRIX_COLUMNS));
    last_col = (col_q == '0);
    last_row = (subrow_q == lmps_pkg::SUBROW_W'(lmps_pkg::SUBROWS - 1));
    last_sf  = (subframe_q == lmps_pkg::SUBFRAME_W'(lmps_pkg::SUBFRAMES - 1));
  end

  always_comb begin
    op_o.kind        = kind;
    op_o.lane        = pixel_row[5:3];
    op_o.pixel       = {blue_value, green_value, red_value};
    op_o.row_select  = subrow_q;
    op_o.latch_after = last_col;
    op_o.frame_end   = last_col && last_row && last_sf;
    op_o.subframe    = subframe_q;
    if (kind == lmps_pkg::REQ_TICK) begin
      op_o.addr = {subrow_q, col_q};
    end else begin
      op_o.addr = {pixel_row[2:0], col_wide[lmps_pkg::COL_W-1:0]};
    end
    // Drop writes outside the panel
    push_o = accept && ((kind == lmps_pkg::REQ_TICK) || in_range);
  end

  always_comb begin
    col_d      = col_q;
    subrow_d   = subrow_q;
    subframe_d = subframe_q;
    if (accept && (kind == lmps_pkg::REQ_TICK)) begin
      if (!last_col) begin
        col_d = col_q - lmps_pkg::COL_W'(1);
      end else begin
        col_d = lmps_pkg::COL_W'(lmps_pkg::MATRIX_COLUMNS - 1);
        if (last_row) begin
          subrow_d   = '0;
          subframe_d = last_sf ? '0 : subframe_q + lmps_pkg::SUBFRAME_W'(1);
        end else begin
          subrow_d = subrow_q + lmps_pkg::SUBROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= lmps_pkg::COL_W'(lmps_pkg::MATRIX_COLUMNS - 1);
      subrow_q   <= '0;
      subframe_q <= '0;
    end else begin
      col_q      <= col_d;
      subrow_q   <= subrow_d;
      subframe_q <= subframe_d;
    end
  end

endmodule

/* hw/rtl/lmps_back.sv */
module lmps_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  lmps_pkg::op_t     op_i,
  output logic              pop_o,
  output lmps_pkg::bstat_t  bstat_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output lmps_pkg::res_t    res_o
);

  logic                              clearing_q, clearing_d;
  logic [lmps_pkg::ADDR_W-1:0]       clr_q, clr_d;

  logic                              room, pop_tick, pop_write;
  logic [lmps_pkg::OB_CNT_W-1:0]     pending;

  logic [lmps_pkg::PIXEL_W-1:0]      rd_q [lmps_pkg::LANES];
  logic                              tick_v_q;
  lmps_pkg::op_t                     meta_q;

  logic [lmps_pkg::SERIAL_W-1:0]     serial;
  lmps_pkg::res_t                    res_d;

  lmps_pkg::res_t                    ob_q [lmps_pkg::OB_DEPTH];
  logic [lmps_pkg::OB_PTR_W-1:0]     ob_wr_q, ob_wr_d, ob_rd_q, ob_rd_d;
  logic [lmps_pkg::OB_CNT_W-1:0]     ob_cnt_q, ob_cnt_d;
  logic                              ob_push, ob_pop;

  assign bstat_o.clearing = clearing_q;

  // Issue a tick only if the result buffer can take it and whatever is in flight
  always_comb begin
    pending   = ob_cnt_q + lmps_pkg::OB_CNT_W'(tick_v_q);
    room      = pending < lmps_pkg::OB_CNT_W'(lmps_pkg::OB_DEPTH);
    pop_o     = !q_empty_i && !clearing_q
             && ((op_i.kind == lmps_pkg::REQ_WRITE) || room);
    pop_tick  = pop_o && (op_i.kind == lmps_pkg::REQ_TICK);
    pop_write = pop_o && (op_i.kind == lmps_pkg::REQ_WRITE);
  end

  always_comb begin
    clr_d      = clearing_q ? clr_q + lmps_pkg::ADDR_W'(1) : clr_q;
    clearing_d = clearing_q && (clr_q != '1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

  // One store per submatrix, all read at the same subrow and column
  for (genvar l = 0; l < lmps_pkg::LANES; l++) begin : g_lane
    logic [lmps_pkg::PIXEL_W-1:0] store_q [lmps_pkg::STORE_DEPTH];

    always_ff @(posedge clk_i) begin
      if (clearing_q) begin
        store_q[clr_q] <= '0;
      end else if (pop_write && (op_i.lane == lmps_pkg::LANE_W'(l))) begin
        store_q[op_i.addr] <= op_i.pixel;
      end
      if (pop_tick) begin
        rd_q[l] <= store_q[op_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_v_q <= 1'b0;
    end else begin
      tick_v_q <= pop_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_tick) begin
      meta_q <= op_i;
    end
  end

  always_comb begin
    serial = '0;
    for (int l = 0; l < lmps_pkg::LANES; l++) begin
      for (int c = 0; c < lmps_pkg::COLOURS; c++) begin
        serial[l * lmps_pkg::COLOURS + c] =
          rd_q[l][c * lmps_pkg::CHAN_W +: lmps_pkg::CHAN_W] > meta_q.subframe;
      end
    end
    res_d.row_select  = meta_q.row_select;
    res_d.serial_bits = serial;
    res_d.latch_after = meta_q.latch_after;
    res_d.frame_end   = meta_q.frame_end;
    res_d.subframe    = meta_q.subframe;
  end

  // Result buffer
  assign m_tvalid_o = (ob_cnt_q != '0);
  assign res_o      = ob_q[ob_rd_q];

  always_comb begin
    ob_push  = tick_v_q;
    ob_pop   = m_tvalid_o && m_tready_i;
    ob_wr_d  = ob_push ? ob_wr_q + lmps_pkg::OB_PTR_W'(1) : ob_wr_q;
    ob_rd_d  = ob_pop  ? ob_rd_q + lmps_pkg::OB_PTR_W'(1) : ob_rd_q;
    ob_cnt_d = ob_cnt_q + lmps_pkg::OB_CNT_W'(ob_push) - lmps_pkg::OB_CNT_W'(ob_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= '0;
      ob_rd_q  <= '0;
      ob_cnt_q <= '0;
    end else begin
      ob_wr_q  <= ob_wr_d;
      ob_rd_q  <= ob_rd_d;
      ob_cnt_q <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_push) begin
      ob_q[ob_wr_q] <= res_d;
    end
  end

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !pop_o)
    else $error("queue popped during frame store sweep");

  a_no_push_into_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_v_q |-> (ob_cnt_q != lmps_pkg::OB_CNT_W'(lmps_pkg::OB_DEPTH)) || ob_pop)
    else $error("result written into full buffer");

  a_tick_reaches_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_tick |=> tick_v_q)
    else $error("issued tick lost before compare stage");

  a_frame_end_on_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_v_q && meta_q.frame_end) |-> meta_q.latch_after)
    else $error("frame end flagged away from column 0");

endmodule

/* hw/rtl/led_matrix_pwm_scan.sv */
// Scan engine for an RGB LED matrix of stacked 8-subrow submatrices. Send a pixel
// write (tuser 0) or a tick (tuser 1) per word; each tick returns one column shift
// with row-select, 15 serial bits, a latch flag on column 0 and a frame-end flag.
// Both sides sustain one word per cycle unless the sweep, a full queue or a stalled
// output holds them: the front keeps the scan counters and queues work; the back
// has one frame store per submatrix, each read once per tick; a tick's result is
// offered after the queue, read registers and result buffer. Writes give no result
// and are seen by every later tick. Reset sweeps all 8 x 2^ceil(log2(columns))
// store addresses (512 for 64 columns) to dark, with s_axis_tready low throughout.
module led_matrix_pwm_scan (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pixel_row[5:0], pixel_col[11:6], red_value[19:12], green_value[27:20],
  // blue_value[35:28], zero pad
  input  logic [lmps_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // req_type[0]
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // row_select[2:0], serial_bits[17:3], subframe_index[25:18], zero pad
  output logic [lmps_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // latch_after
  output logic                                  m_axis_tlast,
  // frame_end[0]
  output logic                                  m_axis_tuser
);

  lmps_pkg::bstat_t bstat;
  lmps_pkg::op_t    push_op, head_op;
  lmps_pkg::res_t   res;
  logic             push, pop, q_full, q_empty;

  lmps_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .bstat_i       (bstat),
    .q_full_i      (q_full),
    .push_o        (push),
    .op_o          (push_op)
  );

  lmps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .op_o    (head_op)
  );

  lmps_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .op_i       (head_op),
    .pop_o      (pop),
    .bstat_o    (bstat),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {(lmps_pkg::OUT_TDATA_W - lmps_pkg::OUT_USED_W)'(0),
                         res.subframe, res.serial_bits, res.row_select};
  assign m_axis_tlast = res.latch_after;
  assign m_axis_tuser = res.frame_end;

endmodule
